/* design/array_list_insert_delete_search_sort_core_defines.svh */
// assertion macros shared by the checker
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_SORT_CORE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_SORT_CORE_DEFINES_SVH

// property checked only outside reset
`define AL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define AL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/alist_pkg.sv */
`default_nettype none
package alist_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    // operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_DUMP   = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0]       position;
        logic [VAL_W-1:0] value;
        logic             last;
    } res_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
    } mem_req_t;
endpackage
`default_nettype wire

/* design/alist_mem.sv */
`default_nettype none
module alist_mem (
    input  wire logic                       aclk,
    input  wire alist_pkg::mem_req_t        req,
    output logic [alist_pkg::VAL_W-1:0]     rd_data
);
    logic [alist_pkg::VAL_W-1:0] mem [alist_pkg::CAPACITY];
    logic [alist_pkg::VAL_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

/* design/alist_ctrl.sv */
`default_nettype none
module alist_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          req_valid,
    input  wire logic [2:0]                    req_op,
    input  wire logic [alist_pkg::VAL_W-1:0]   req_elem,
    output logic                               req_ready,
    input  wire logic                          out_free,
    output logic                               emit,
    output alist_pkg::res_t                    res,
    output alist_pkg::mem_req_t                mreq,
    input  wire logic [alist_pkg::VAL_W-1:0]   rd_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INS   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DWR   = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PEM   = 4'd7;
    localparam logic [3:0] S_TKEY  = 4'd8;
    localparam logic [3:0] S_TKEYW = 4'd9;
    localparam logic [3:0] S_TCRD  = 4'd10;
    localparam logic [3:0] S_TCMP  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    localparam int CW = alist_pkg::CNT_W;
    localparam int IW = alist_pkg::IDX_W;

    logic [3:0]                     state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  j_reg, j_next;
    logic [2:0]                     op_reg, op_next;
    logic [alist_pkg::VAL_W-1:0]    elem_reg, elem_next;
    logic [alist_pkg::VAL_W-1:0]    key_reg, key_next;
    alist_pkg::res_t                res_reg, res_next;
    logic [CW-1:0]                  idx_inc;
    logic [CW-1:0]                  j_dec;

    assign idx_inc   = idx_reg + CW'(1);
    assign j_dec     = j_reg - CW'(1);
    assign req_ready = (state_reg == S_IDLE);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        op_reg   <= op_next;
        elem_reg <= elem_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        op_next    = op_reg;
        elem_next  = elem_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        emit       = 1'b0;
        res        = res_reg;
        mreq       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next   = req_op;
                    elem_next = req_elem;
                    idx_next  = '0;
                    res_next  = '{status: alist_pkg::ST_OK, position: '0,
                                  value: '0, last: 1'b1};
                    priority case (req_op)
                        alist_pkg::OP_INSERT: state_next = S_INS;
                        alist_pkg::OP_DELETE,
                        alist_pkg::OP_SEARCH: state_next = S_SRD;
                        alist_pkg::OP_DUMP: begin
                            if (cnt_reg == '0) begin
                                res_next.status = alist_pkg::ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_PRD;
                            end
                        end
                        alist_pkg::OP_SORT: begin
                            if (cnt_reg == '0) begin
                                res_next.status = alist_pkg::ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                idx_next   = CW'(1);
                                state_next = S_TKEY;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            // append or report full
            S_INS: begin
                if (cnt_reg == CW'(alist_pkg::CAPACITY)) begin
                    res_next.status = alist_pkg::ST_FULL;
                end else begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = cnt_reg[IW-1:0];
                    mreq.wr_data = elem_reg;
                    cnt_next     = cnt_reg + CW'(1);
                end
                state_next = S_EMIT;
            end
            // linear scan for the first match
            S_SRD: begin
                if (idx_reg == cnt_reg) begin
                    res_next.status = alist_pkg::ST_NOT_FOUND;
                    state_next      = S_EMIT;
                end else begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = idx_reg[IW-1:0];
                    state_next   = S_SCMP;
                end
            end
            S_SCMP: begin
                if (rd_data == elem_reg) begin
                    res_next.position = 6'(idx_reg[IW-1:0]);
                    state_next = (op_reg == alist_pkg::OP_DELETE) ? S_DRD : S_EMIT;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_SRD;
                end
            end
            // close the gap: read the next entry, write it one place down
            S_DRD: begin
                if (idx_inc >= cnt_reg) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_EMIT;
                end else begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = idx_inc[IW-1:0];
                    state_next   = S_DWR;
                end
            end
            S_DWR: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = idx_reg[IW-1:0];
                mreq.wr_data = rd_data;
                idx_next     = idx_inc;
                state_next   = S_DRD;
            end
            // dump walk
            S_PRD: begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = idx_reg[IW-1:0];
                state_next   = S_PEM;
            end
            S_PEM: begin
                res = '{status: alist_pkg::ST_OK, position: 6'(idx_reg[IW-1:0]),
                        value: rd_data, last: (idx_inc == cnt_reg)};
                if (out_free) begin
                    emit     = 1'b1;
                    idx_next = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? S_IDLE : S_PRD;
                end
            end
            // insertion sort: fetch key
            S_TKEY: begin
                if (idx_reg >= cnt_reg) begin
                    state_next = S_EMIT;
                end else begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = idx_reg[IW-1:0];
                    state_next   = S_TKEYW;
                end
            end
            S_TKEYW: begin
                key_next   = rd_data;
                j_next     = idx_reg;
                state_next = S_TCRD;
            end
            S_TCRD: begin
                if (j_reg == '0) begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = j_reg[IW-1:0];
                    mreq.wr_data = key_reg;
                    idx_next     = idx_inc;
                    state_next   = S_TKEY;
                end else begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = j_dec[IW-1:0];
                    state_next   = S_TCMP;
                end
            end
            S_TCMP: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = j_reg[IW-1:0];
                if ($signed(key_reg) < $signed(rd_data)) begin
                    mreq.wr_data = rd_data;
                    j_next       = j_dec;
                    state_next   = S_TCRD;
                end else begin
                    mreq.wr_data = key_reg;
                    idx_next     = idx_inc;
                    state_next   = S_TKEY;
                end
            end
            // single result
            S_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* design/array_list_insert_delete_search_sort_core.sv */
// Ordered list of up to 64 signed 32-bit entries held in a single-port-read,
// single-port-write memory with a registered read. One request is worked at a
// time: insert writes the new entry at the end, search and delete scan the
// entries in order, delete then moves each later entry down one place, dump
// emits one result per entry, and sort (insertion sort) fetches each key and
// shifts larger elements up before writing it back. The pace is set by the
// registered memory read in each step of the sequencer. A result sits in an
// output register, so a new request is taken while it waits.
`default_nettype none
module array_list_insert_delete_search_sort_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op[2:0], element[34:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // position[5:0], entry_value[37:6], zero pad
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast
);
    alist_pkg::mem_req_t          mreq;
    alist_pkg::res_t              res;
    logic [alist_pkg::VAL_W-1:0]  rd_data;
    logic                         emit;
    logic                         out_free;
    logic                         m_tvalid_reg;
    alist_pkg::res_t              out_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    alist_mem u_mem (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    alist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_op    (s_tdata[2:0]),
        .req_elem  (s_tdata[34:3]),
        .req_ready (s_tready),
        .out_free  (out_free),
        .emit      (emit),
        .res       (res),
        .mreq      (mreq),
        .rd_data   (rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.value, out_reg.position};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
endmodule
`default_nettype wire

/* design/alist_chk.sv */
`default_nettype none
`include "array_list_insert_delete_search_sort_core_defines.svh"
module alist_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    // a stalled result holds
    `AL_ASSERT(a_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast), "stalled result changed")
    // no result straight out of reset
    `AL_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    // one request at a time; unknown operations are dropped at once
    `AL_ASSERT(a_busy, aclk, aresetn,
        s_tvalid && s_tready && (s_tdata[2:0] <= alist_pkg::OP_SORT) |=> !s_tready,
        "request taken while busy")
    // only insert may report full, and then with zero payload
    `AL_ASSERT(a_full, aclk, aresetn,
        m_tvalid && m_tuser == alist_pkg::ST_FULL |-> m_tdata == 40'd0 && m_tlast,
        "bad full result")
endmodule

bind array_list_insert_delete_search_sort_core alist_chk u_chk (.*);
`default_nettype wire

/* bench/array_list_insert_delete_search_sort_core_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module array_list_insert_delete_search_sort_core_test;

    // expected list response
    typedef struct {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] value;
        logic        last;
    } list_resp_t;

    // list model and queue of pending responses
    class list_scoreboard;
        logic [31:0] entries[alist_pkg::CAPACITY];
        int          count;
        list_resp_t  pending[$];
        int          errors;
        int          checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function void push(logic [1:0] st, logic [5:0] pos, logic [31:0] v, logic l);
            list_resp_t r;
            r.status = st;
            r.position = pos;
            r.value = v;
            r.last = l;
            pending.push_back(r);
        endfunction

        function int find_first(logic [31:0] v);
            for (int i = 0; i < count; i++)
                if (entries[i] == v) return i;
            return -1;
        endfunction

        // note an accepted request and predict its responses
        function void note_request(logic [2:0] op, logic [31:0] v);
            int idx;
            int j;
            logic [31:0] key;
            case (op)
                alist_pkg::OP_INSERT: begin
                    if (count < alist_pkg::CAPACITY) begin
                        entries[count] = v;
                        count++;
                        push(alist_pkg::ST_OK, 0, 0, 1);
                    end else begin
                        push(alist_pkg::ST_FULL, 0, 0, 1);
                    end
                end
                alist_pkg::OP_DELETE: begin
                    idx = find_first(v);
                    if (idx >= 0) begin
                        for (j = idx; j + 1 < count; j++) entries[j] = entries[j+1];
                        count--;
                        push(alist_pkg::ST_OK, idx[5:0], 0, 1);
                    end else begin
                        push(alist_pkg::ST_NOT_FOUND, 0, 0, 1);
                    end
                end
                alist_pkg::OP_SEARCH: begin
                    idx = find_first(v);
                    if (idx >= 0) push(alist_pkg::ST_OK, idx[5:0], 0, 1);
                    else push(alist_pkg::ST_NOT_FOUND, 0, 0, 1);
                end
                alist_pkg::OP_DUMP: begin
                    if (count == 0) push(alist_pkg::ST_EMPTY, 0, 0, 1);
                    else
                        for (int i = 0; i < count; i++)
                            push(alist_pkg::ST_OK, i[5:0], entries[i], i + 1 == count);
                end
                alist_pkg::OP_SORT: begin
                    if (count == 0) begin
                        push(alist_pkg::ST_EMPTY, 0, 0, 1);
                    end else begin
                        // insertion sort, signed order
                        for (int i = 1; i < count; i++) begin
                            key = entries[i];
                            j = i;
                            while (j > 0 && $signed(key) < $signed(entries[j-1])) begin
                                entries[j] = entries[j-1];
                                j--;
                            end
                            entries[j] = key;
                        end
                        push(alist_pkg::ST_OK, 0, 0, 1);
                    end
                end
                default: ;
            endcase
        endfunction

        // compare one response with the oldest expectation
        task check_response(logic [1:0] st, logic [5:0] pos, logic [31:0] v, logic l);
            list_resp_t e;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected response st=%0d pos=%0d", st, pos));
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || pos !== e.position || v !== e.value || l !== e.last)
                report_mismatch($sformatf(
                    "got st=%0d pos=%0d val=%h last=%b, want st=%0d pos=%0d val=%h last=%b",
                    st, pos, v, l, e.status, e.position, e.value, e.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    list_scoreboard sb;
    bit  quiet_mode;
    int  requests_sent;
    int  dumps_sent;
    int  sorts_sent;

    array_list_insert_delete_search_sort_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    // hard stop
    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

    // response side: random stalls, sample at the edge
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata[5:0], m_tdata[37:6], m_tlast);
        end
    end

    // send one request, with an optional idle burst first
    task automatic send_request(logic [2:0] op, logic [31:0] v);
        int gap;
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, v, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, v);
        requests_sent++;
        if (op == alist_pkg::OP_DUMP) dumps_sent++;
        if (op == alist_pkg::OP_SORT) sorts_sent++;
    endtask

    task automatic drain_responses();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        int i;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: begin
                // reuse stored values so searches and deletes hit
                if (sb.count > 0 && $urandom_range(0, 2) != 0) begin
                    i = $urandom_range(0, sb.count - 1);
                    return sb.entries[i];
                end
                return $urandom_range(0, 15) - 8;
            end
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        sb = new();
        quiet_mode = 1'b0;
        requests_sent = 0;
        dumps_sent = 0;
        sorts_sent = 0;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list cases, extremes, unknown op
        send_request(alist_pkg::OP_DUMP, 0);
        send_request(alist_pkg::OP_SORT, 0);
        send_request(alist_pkg::OP_SEARCH, 32'h7fff_ffff);
        send_request(alist_pkg::OP_DELETE, 32'h8000_0000);
        send_request(3'd5, 32'hffff_ffff);
        send_request(alist_pkg::OP_INSERT, 32'h7fff_ffff);
        send_request(alist_pkg::OP_INSERT, 32'h8000_0000);
        send_request(alist_pkg::OP_INSERT, 32'hffff_ffff);
        send_request(alist_pkg::OP_INSERT, 32'h0000_0000);
        send_request(alist_pkg::OP_INSERT, 32'h8000_0000);
        send_request(3'd6, 0);
        send_request(3'd7, 32'h5555_aaaa);
        send_request(alist_pkg::OP_SEARCH, 32'h8000_0000);
        send_request(alist_pkg::OP_SORT, 0);
        send_request(alist_pkg::OP_DUMP, 0);
        send_request(alist_pkg::OP_DELETE, 32'h8000_0000);
        send_request(alist_pkg::OP_DELETE, 32'h1234_5678);
        send_request(alist_pkg::OP_DUMP, 0);
        drain_responses();

        // fill past capacity to see the full status
        while (sb.count < alist_pkg::CAPACITY) send_request(alist_pkg::OP_INSERT, $urandom());
        send_request(alist_pkg::OP_INSERT, 32'haaaa_5555);
        send_request(alist_pkg::OP_DUMP, 0);
        send_request(alist_pkg::OP_SORT, 0);
        send_request(alist_pkg::OP_DUMP, 0);
        // empty it again by deleting from the front
        while (sb.count > 0) send_request(alist_pkg::OP_DELETE, sb.entries[0]);

        // random part
        for (int n = 0; n < 280; n++) begin
            if (n == 240) begin
                drain_responses();
                quiet_mode = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: op = alist_pkg::OP_INSERT;
                7, 8, 9:             op = alist_pkg::OP_DELETE;
                10, 11, 12:          op = alist_pkg::OP_SEARCH;
                13, 14:              op = alist_pkg::OP_DUMP;
                15, 16:              op = alist_pkg::OP_SORT;
                17:                  op = 3'($urandom_range(5, 7));
                default: op = (sb.count > 40) ? alist_pkg::OP_DELETE : alist_pkg::OP_INSERT;
            endcase
            send_request(op, pick_value());
        end

        drain_responses();
        repeat (200) @(posedge aclk);
        $display("%0d requests sent (%0d dumps, %0d sorts), %0d responses checked",
                 requests_sent, dumps_sent, sorts_sent, sb.checked);
        $display("covered empty, full and unknown-op cases with random stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/alist_pkg.sv
design/alist_mem.sv
design/alist_ctrl.sv
design/array_list_insert_delete_search_sort_core.sv
design/alist_chk.sv
bench/array_list_insert_delete_search_sort_core_test.sv
